FILE: src/drs_pkg.sv
// ----------------------------------------------------------------------------
// Disk request scheduler package
// Shared types and constants for the scheduler cells and the top level.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int MaxRequests = 16;
  localparam int IdxW = $clog2(MaxRequests);
  localparam int CntW = $clog2(MaxRequests + 1);
  localparam int TrackW = 16;
  localparam int SumW = 21;

  localparam logic [2:0] ALG_FCFS = 3'd0;
  localparam logic [2:0] ALG_SCAN = 3'd1;
  localparam logic [2:0] ALG_CSCAN = 3'd2;
  localparam logic [2:0] ALG_LOOK = 3'd3;
  localparam logic [2:0] ALG_CLOOK = 3'd4;
  localparam logic [2:0] ALG_SSTF = 3'd5;

  localparam logic [1:0] CFG_ALGORITHM = 2'd0;
  localparam logic [1:0] CFG_SWEEP_DOWN = 2'd1;
  localparam logic [1:0] CFG_LAST_TRACK = 2'd2;
  localparam logic [1:0] CFG_START_HEAD = 2'd3;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT,
    ST_PICK,
    ST_EMIT,
    ST_DONE
  } state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              load;    // shift a new track into the chain
    logic              sort_odd; // odd/even transposition phase select
    logic              sort_en;
    logic              clear;   // end of run, drop all entries
    logic              mark;    // mark the selected entry served
    logic [IdxW-1:0]   mark_idx;
  } cell_ctrl_t;

  function automatic logic [TrackW-1:0] abs_diff(input logic [TrackW-1:0] a,
                                                  input logic [TrackW-1:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

endpackage

FILE: src/drs_cell.sv
// ----------------------------------------------------------------------------
// Scheduler storage cell
// Holds one request word with valid and served flags; takes part in the
// shift-in load and in odd/even transposition sorting with its neighbors.
// ----------------------------------------------------------------------------
module drs_cell import drs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [IdxW-1:0]   pos,
  input  logic              sort_en,     // this cell pairs upward in this phase
  input  logic              sort_lo,     // this cell is the upper of a pair
  input  logic [TrackW-1:0] prev_track,  // neighbor below
  input  logic              prev_valid,
  input  logic [TrackW-1:0] next_track,  // neighbor above
  input  logic              next_valid,
  input  logic [TrackW-1:0] load_track,  // value written when this is the tail
  input  logic              load_here,
  output logic [TrackW-1:0] track,
  output logic              valid,
  output logic              served
);

  logic [TrackW-1:0] track_r, track_nxt;
  logic valid_r, valid_nxt, served_r, served_nxt;

  // Compare-exchange with the neighbor; invalid entries count as largest.
  always_comb begin
    track_nxt = track_r;
    valid_nxt = valid_r;
    served_nxt = served_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
      served_nxt = 1'b0;
    end else if (ctrl.load && load_here) begin
      track_nxt = load_track;
      valid_nxt = 1'b1;
    end else if (ctrl.sort_en && sort_en && valid_r && next_valid &&
                 next_track < track_r) begin
      track_nxt = next_track;
    end else if (ctrl.sort_en && sort_lo && valid_r && prev_valid &&
                 track_r < prev_track) begin
      track_nxt = prev_track;
    end else if (ctrl.mark && ctrl.mark_idx == pos) begin
      served_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      served_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      served_r <= served_nxt;
    end
    track_r <= track_nxt;
  end

  assign track = track_r;
  assign valid = valid_r;
  assign served = served_r;

endmodule

FILE: src/drs_seek.sv
// ----------------------------------------------------------------------------
// Nearest-request search
// Scans the cells one per cycle while step is high and keeps the unserved
// entry nearest to the head, earliest index winning ties.
// ----------------------------------------------------------------------------
module drs_seek import drs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              step,
  input  logic [TrackW-1:0] head,
  input  logic [TrackW-1:0] cand_track,
  input  logic              cand_ok,
  input  logic [IdxW-1:0]   cand_idx,
  output logic              found,
  output logic [IdxW-1:0]   best_idx,
  output logic [TrackW-1:0] best_track
);

  logic found_r, found_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [TrackW-1:0] trk_r, trk_nxt, dist_r, dist_nxt, d;

  // Keep the candidate if strictly closer than the best so far.
  always_comb begin
    d = abs_diff(cand_track, head);
    found_nxt = found_r;
    idx_nxt = idx_r;
    trk_nxt = trk_r;
    dist_nxt = dist_r;
    if (start) begin
      found_nxt = 1'b0;
    end else if (step && cand_ok && (!found_r || d < dist_r)) begin
      found_nxt = 1'b1;
      idx_nxt = cand_idx;
      trk_nxt = cand_track;
      dist_nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    idx_r <= idx_nxt;
    trk_r <= trk_nxt;
    dist_r <= dist_nxt;
  end

  assign found = found_r;
  assign best_idx = idx_r;
  assign best_track = trk_r;

endmodule

FILE: src/disk_request_scheduler_top.sv
// ----------------------------------------------------------------------------
// Disk request scheduler top level
// Collects requests in a chain of cells and emits the service order.
// ----------------------------------------------------------------------------
// Requests are taken one word per cycle into a chain of 16 cells. The word
// marked tlast starts the schedule: the sweep algorithms first sort the chain
// with odd/even transposition (one compare-exchange phase per cycle, 16
// phases), then walk it; SSTF scans the stored cells once per served
// request. Each result word is held in an output register; the next
// result is computed while it waits. Input is not taken again until the
// last result of the batch has left.
module disk_request_scheduler_top import drs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] request_track
  input  logic        in_tlast,   // last_request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] served_track, [36:16] total_movement
  output logic        out_tuser,  // is_boundary
  output logic        out_tlast   // end_of_run
);

  // Configuration registers.
  logic [2:0] alg_r;
  logic down_r;
  logic [TrackW-1:0] last_r, start_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r <= ALG_FCFS;
      down_r <= 1'b0;
      last_r <= 16'd199;
      start_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALGORITHM:  alg_r <= cfg_data[2:0];
        CFG_SWEEP_DOWN: down_r <= cfg_data[0];
        CFG_LAST_TRACK: last_r <= cfg_data;
        CFG_START_HEAD: start_r <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;           // stored requests
  logic [CntW-1:0] ptr_r, ptr_nxt;           // walk / scan pointer
  logic [CntW-1:0] done_r, done_nxt;         // results of requests emitted
  logic [2:0] phase_r, phase_nxt;            // sweep segment
  logic [TrackW-1:0] head_r, head_nxt;
  logic [SumW-1:0] sum_r, sum_nxt;
  logic ovalid_r, ovalid_nxt, olast_r, olast_nxt, obnd_r, obnd_nxt;
  logic [TrackW-1:0] otrk_r, otrk_nxt;
  logic [SumW-1:0] osum_r, osum_nxt;
  logic [CntW-1:0] split_r, split_nxt;

  cell_ctrl_t ctrl;
  logic [TrackW-1:0] trk [MaxRequests];
  logic vld [MaxRequests];
  logic srv [MaxRequests];
  logic [TrackW-1:0] in_clamped;
  logic in_acc, out_free;

  assign in_clamped = (in_tdata > last_r) ? last_r : in_tdata;
  assign in_acc = in_tvalid && in_tready;
  assign out_free = !ovalid_r || out_tready;

  // Chain of cells.
  for (genvar g = 0; g < MaxRequests; g++) begin : g_cell
    logic pe, pl;
    assign pe = (g + 1 < MaxRequests) && ((g % 2) == int'(ctrl.sort_odd));
    assign pl = (g > 0) && (((g - 1) % 2) == int'(ctrl.sort_odd));
    drs_cell u_cell (
      .clk, .rst_n, .ctrl,
      .pos        (IdxW'(g)),
      .sort_en    (pe),
      .sort_lo    (pl),
      .prev_track (trk[(g > 0) ? g - 1 : 0]),
      .prev_valid (vld[(g > 0) ? g - 1 : 0]),
      .next_track (trk[(g + 1 < MaxRequests) ? g + 1 : g]),
      .next_valid (vld[(g + 1 < MaxRequests) ? g + 1 : g]),
      .load_track (in_clamped),
      .load_here  (cnt_r == CntW'(g)),
      .track      (trk[g]),
      .valid      (vld[g]),
      .served     (srv[g])
    );
  end

  // SSTF search unit reads one cell per cycle through the pointer.
  logic [IdxW-1:0] pidx;
  logic [TrackW-1:0] ptrk;
  logic seek_found, seek_start, seek_step;
  logic [IdxW-1:0] seek_idx;
  logic [TrackW-1:0] seek_trk;
  assign pidx = ptr_r[IdxW-1:0];
  assign ptrk = trk[pidx];

  drs_seek u_seek (
    .clk, .rst_n,
    .start      (seek_start),
    .step       (seek_step),
    .head       (head_r),
    .cand_track (ptrk),
    .cand_ok    (ptr_r < cnt_r && !srv[pidx]),
    .cand_idx   (pidx),
    .found      (seek_found),
    .best_idx   (seek_idx),
    .best_track (seek_trk)
  );

  // Next state.
  logic sweep_alg, sort_done, emit_go, emit_bnd, emit_end;
  logic [TrackW-1:0] emit_trk;
  logic [SumW-1:0] sum_new;
  assign sweep_alg = (alg_r == ALG_SCAN) || (alg_r == ALG_CSCAN) ||
                     (alg_r == ALG_LOOK) || (alg_r == ALG_CLOOK);
  assign sort_done = ptr_r == CntW'(MaxRequests);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_acc && in_tlast) state_nxt = sweep_alg ? ST_SORT : ST_EMIT;
      ST_SORT: if (sort_done) state_nxt = ST_PICK;
      ST_PICK: if (emit_go && emit_end) state_nxt = ST_DONE;
      ST_EMIT: if (emit_go && emit_end) state_nxt = ST_DONE;
      ST_DONE: if (!ovalid_r) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Sweep walk: phases 4 split, 0 first run, 1 far boundary, 2 wrap
  // boundary, 3 second run. SSTF: ptr scans stored cells, emits the winner.
  logic up;
  logic [CntW-1:0] sidx;
  assign up = !down_r;
  always_comb begin
    emit_go = 1'b0;
    emit_bnd = 1'b0;
    emit_trk = '0;
    emit_end = 1'b0;
    seek_start = 1'b0;
    seek_step = 1'b0;
    sidx = '0;
    ptr_nxt = ptr_r;
    phase_nxt = phase_r;
    done_nxt = done_r;
    split_nxt = split_r;
    ctrl = '0;
    ctrl.mark_idx = seek_idx;
    ctrl.sort_odd = ptr_r[0];
    unique case (state_r)
      ST_LOAD: begin
        ctrl.load = in_acc && (cnt_r < CntW'(MaxRequests));
        ptr_nxt = '0;
        phase_nxt = '0;
        done_nxt = '0;
        split_nxt = '0;
      end
      ST_SORT: begin
        ctrl.sort_en = !sort_done;
        ptr_nxt = sort_done ? '0 : ptr_r + 1'b1;
      end
      ST_PICK: begin
        if (phase_r == 3'd4) begin
          // Find split: first sorted entry at or above the head.
          if (ptr_r < cnt_r && trk[pidx] < head_r) begin
            ptr_nxt = ptr_r + 1'b1;
          end else begin
            split_nxt = ptr_r;
            phase_nxt = 3'd0;
            ptr_nxt = up ? ptr_r : ptr_r;
          end
        end else if (out_free) begin
          unique case (phase_r)
            3'd0: begin
              if (up ? (ptr_r < cnt_r) : (ptr_r > 0)) begin
                sidx = up ? ptr_r : ptr_r - 1'b1;
                emit_go = 1'b1;
                emit_trk = trk[sidx[IdxW-1:0]];
                ptr_nxt = up ? ptr_r + 1'b1 : ptr_r - 1'b1;
              end else begin
                phase_nxt = 3'd1;
              end
            end
            3'd1: begin
              phase_nxt = 3'd2;
              if (alg_r == ALG_SCAN || alg_r == ALG_CSCAN) begin
                emit_go = 1'b1;
                emit_bnd = 1'b1;
                emit_trk = up ? last_r : '0;
              end
              ptr_nxt = (alg_r == ALG_SCAN || alg_r == ALG_LOOK) ? split_r :
                        (up ? '0 : cnt_r);
            end
            3'd2: begin
              phase_nxt = 3'd3;
              if (alg_r == ALG_CSCAN && (up ? split_r > 0 : split_r < cnt_r)) begin
                emit_go = 1'b1;
                emit_bnd = 1'b1;
                emit_trk = up ? '0 : last_r;
              end
            end
            default: begin
              // Second run, direction set by the algorithm and the sweep direction.
              if ((alg_r == ALG_SCAN || alg_r == ALG_LOOK) ? up : !up) begin
                if (ptr_r > 0 && ((alg_r == ALG_SCAN || alg_r == ALG_LOOK) ||
                                  ptr_r > split_r)) begin
                  sidx = ptr_r - 1'b1;
                  emit_go = 1'b1;
                  emit_trk = trk[sidx[IdxW-1:0]];
                  ptr_nxt = ptr_r - 1'b1;
                end
              end else begin
                if (ptr_r < ((alg_r == ALG_SCAN || alg_r == ALG_LOOK) ? cnt_r :
                             split_r)) begin
                  sidx = ptr_r;
                  emit_go = 1'b1;
                  emit_trk = trk[sidx[IdxW-1:0]];
                  ptr_nxt = ptr_r + 1'b1;
                end
              end
            end
          endcase
          if (emit_go && !emit_bnd) done_nxt = done_r + 1'b1;
          // The far boundary of SCAN and C-SCAN always follows the first run.
          emit_end = emit_go && !emit_bnd && (done_r + 1'b1 == cnt_r) &&
                     !(phase_r == 3'd0 && (alg_r == ALG_SCAN || alg_r == ALG_CSCAN));
          // A boundary is last only if no requests follow it.
          if (emit_go && emit_bnd && done_r == cnt_r &&
              !(phase_r == 3'd1 && alg_r == ALG_CSCAN &&
                (up ? split_r > 0 : split_r < cnt_r)))
            emit_end = 1'b1;
        end
      end
      ST_EMIT: begin
        if (alg_r == ALG_SSTF) begin
          if (ptr_r <= cnt_r && ptr_r < CntW'(MaxRequests)) begin
            seek_step = 1'b1;
            seek_start = (ptr_r == 0) && (phase_r == 3'd0);
            if (seek_start) seek_step = 1'b0;
            phase_nxt = 3'd1;
            ptr_nxt = ptr_r + 1'b1;
            if (seek_start) ptr_nxt = ptr_r;
          end else if (out_free) begin
            emit_go = 1'b1;
            emit_trk = seek_trk;
            ctrl.mark = 1'b1;
            done_nxt = done_r + 1'b1;
            emit_end = done_r + 1'b1 == cnt_r;
            ptr_nxt = '0;
            phase_nxt = 3'd0;
          end
          if (!seek_found && ptr_r >= cnt_r && phase_r != 3'd0) ptr_nxt = ptr_r;
        end else if (out_free && ptr_r < cnt_r) begin
          emit_go = 1'b1;
          emit_trk = trk[pidx];
          ptr_nxt = ptr_r + 1'b1;
          done_nxt = done_r + 1'b1;
          emit_end = ptr_r + 1'b1 == cnt_r;
        end
      end
      default: begin
        ctrl.clear = !ovalid_r;
      end
    endcase
    if (state_r == ST_SORT && sort_done) phase_nxt = 3'd4;
  end

  // Head, movement sum and the output register.
  assign sum_new = sum_r + SumW'(abs_diff(emit_trk, head_r));
  always_comb begin
    head_nxt = head_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    ovalid_nxt = ovalid_r && !out_tready;
    otrk_nxt = otrk_r;
    obnd_nxt = obnd_r;
    osum_nxt = osum_r;
    olast_nxt = olast_r;
    if (state_r == ST_LOAD) begin
      head_nxt = (start_r > last_r) ? last_r : start_r;
      sum_nxt = '0;
      if (ctrl.load) cnt_nxt = cnt_r + 1'b1;
    end
    if (emit_go) begin
      head_nxt = emit_trk;
      sum_nxt = sum_new;
      ovalid_nxt = 1'b1;
      otrk_nxt = emit_trk;
      obnd_nxt = emit_bnd;
      olast_nxt = emit_end;
      osum_nxt = emit_end ? sum_new : '0;
    end
    if (state_r == ST_DONE && !ovalid_r) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r <= '0;
      ptr_r <= '0;
      done_r <= '0;
      phase_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= (cnt_nxt == '0 && state_r == ST_LOAD) ? ST_LOAD : state_nxt;
      cnt_r <= cnt_nxt;
      ptr_r <= ptr_nxt;
      done_r <= done_nxt;
      phase_r <= phase_nxt;
      ovalid_r <= ovalid_nxt;
    end
    head_r <= head_nxt;
    sum_r <= sum_nxt;
    otrk_r <= otrk_nxt;
    obnd_r <= obnd_nxt;
    osum_r <= osum_nxt;
    olast_r <= olast_nxt;
    split_r <= split_nxt;
  end

  assign in_tready = (state_r == ST_LOAD);
  assign out_tvalid = ovalid_r;
  assign out_tdata = {3'b000, osum_r, otrk_r};
  assign out_tuser = obnd_r;
  assign out_tlast = olast_r;

  // Checks on the sequencer and output register.
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_tready) else $error("input taken while results pending");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxRequests)) else $error("request count overflow");
  a_sum_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !olast_r) |-> osum_r == '0) else $error("sum on non-final word");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Disk request scheduler testbench
// Sends batches of track requests under every algorithm and sweep direction,
// predicts each service order and head travel, and checks every result word.
// ----------------------------------------------------------------------------
module testbench import drs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] request_track
  logic        in_tlast;   // last_request
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [15:0] served_track, [36:16] total_movement
  logic        out_tuser;  // is_boundary
  logic        out_tlast;  // end_of_run

  typedef struct {
    logic [15:0] track;
    logic        boundary;
    logic [20:0] travel;
    logic        run_end;
  } visit_t;

  disk_request_scheduler_top dut (.*);

  // Scheduler settings as the block holds them.
  logic [2:0]  sched_alg;
  logic        sched_down;
  logic [15:0] sched_last;
  logic [15:0] sched_start;

  // Pending batch and the visits still owed by the block.
  logic [15:0] batch[$];
  visit_t      visits_due[$];
  logic [15:0] head;
  logic [20:0] travel;

  int errors;
  int batches;
  int results_seen;
  bit idle_on;
  bit hold_out;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // Append one visit and accumulate head travel.
  function automatic void visit(input logic [15:0] t, input logic b);
    visit_t v;
    travel = travel + ((t > head) ? 21'(t - head) : 21'(head - t));
    head = t;
    v.track = t;
    v.boundary = b;
    v.travel = '0;
    v.run_end = 1'b0;
    visits_due = {visits_due, v};
  endfunction

  // Work out the service order of the stored batch.
  function automatic void plan_schedule();
    logic [15:0] s[$];
    bit done[16];
    int n, split, best;
    logic [15:0] d, bd;
    bit up;
    int first;
    n = batch.size();
    first = visits_due.size();
    travel = '0;
    head = (sched_start > sched_last) ? sched_last : sched_start;
    up = !sched_down;
    if (sched_alg == ALG_SSTF) begin
      foreach (done[i]) done[i] = 0;
      for (int r = 0; r < n; r++) begin
        best = -1;
        bd = '0;
        for (int j = 0; j < n; j++) begin
          if (done[j]) continue;
          d = (batch[j] > head) ? batch[j] - head : head - batch[j];
          if (best < 0 || d < bd) begin
            best = j;
            bd = d;
          end
        end
        done[best] = 1;
        visit(batch[best], 1'b0);
      end
    end else if (sched_alg >= ALG_SCAN && sched_alg <= ALG_CLOOK) begin
      s = batch;
      s.sort();
      split = 0;
      while (split < n && s[split] < head) split++;
      if (up) begin
        for (int i = split; i < n; i++) visit(s[i], 1'b0);
        if (sched_alg == ALG_SCAN || sched_alg == ALG_CSCAN) visit(sched_last, 1'b1);
        if (sched_alg == ALG_SCAN || sched_alg == ALG_LOOK) begin
          for (int i = split - 1; i >= 0; i--) visit(s[i], 1'b0);
        end else begin
          if (sched_alg == ALG_CSCAN && split > 0) visit(16'd0, 1'b1);
          for (int i = 0; i < split; i++) visit(s[i], 1'b0);
        end
      end else begin
        for (int i = split - 1; i >= 0; i--) visit(s[i], 1'b0);
        if (sched_alg == ALG_SCAN || sched_alg == ALG_CSCAN) visit(16'd0, 1'b1);
        if (sched_alg == ALG_SCAN || sched_alg == ALG_LOOK) begin
          for (int i = split; i < n; i++) visit(s[i], 1'b0);
        end else begin
          if (sched_alg == ALG_CSCAN && split < n) visit(sched_last, 1'b1);
          for (int i = n - 1; i >= split; i--) visit(s[i], 1'b0);
        end
      end
    end else begin
      for (int i = 0; i < n; i++) visit(batch[i], 1'b0);
    end
    if (visits_due.size() > first) begin
      visits_due[visits_due.size() - 1].travel = travel;
      visits_due[visits_due.size() - 1].run_end = 1'b1;
    end
    batch.delete();
    batches++;
  endfunction

  // Random sender gap; the valid line drops for the length of the gap.
  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Send one request word and update the prediction on acceptance.
  task automatic send_request(input logic [15:0] t, input logic last);
    logic [15:0] c;
    sender_gap();
    in_tvalid <= 1'b1;
    in_tdata <= t;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    c = (t > sched_last) ? sched_last : t;
    if (batch.size() < MaxRequests) batch = {batch, c};
    if (last) plan_schedule();
  endtask

  // Wait until every expected result has arrived, then let the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (visits_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ALGORITHM:  sched_alg = val[2:0];
      CFG_SWEEP_DOWN: sched_down = val[0];
      CFG_LAST_TRACK: sched_last = val;
      CFG_START_HEAD: sched_start = val;
      default: ;
    endcase
  endtask

  task automatic setup(input logic [2:0] alg, input logic down,
                       input logic [15:0] last, input logic [15:0] start);
    drain();
    write_reg(CFG_ALGORITHM, {13'd0, alg});
    write_reg(CFG_SWEEP_DOWN, {15'd0, down});
    write_reg(CFG_LAST_TRACK, last);
    write_reg(CFG_START_HEAD, start);
    cfg_valid <= 1'b0;
  endtask

  // Send a batch of n random tracks, mostly within the last track.
  task automatic random_batch(input int n);
    logic [15:0] t;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: t = 16'hFFFF;
        1: t = 16'($urandom);
        2: t = sched_start;
        default: t = 16'($urandom_range(0, sched_last));
      endcase
      send_request(t, i == n - 1);
    end
  endtask

  // Extremes, head-equal requests, clamping and every algorithm.
  task automatic test_directed();
    setup(ALG_FCFS, 1'b0, 16'd199, 16'd0);
    send_request(16'd0, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd199, 1'b1);
    for (int a = 0; a < 8; a++) begin
      setup(3'(a), 1'(a & 1), 16'd199, 16'd53);
      send_request(16'd98, 1'b0);
      send_request(16'd53, 1'b0);
      send_request(16'd14, 1'b0);
      send_request(16'd124, 1'b1);
    end
    // SSTF tie: two requests equally far from the head.
    setup(ALG_SSTF, 1'b0, 16'hFFFF, 16'd100);
    send_request(16'd110, 1'b0);
    send_request(16'd90, 1'b1);
    // C-SCAN with nothing on the far side, both directions.
    setup(ALG_CSCAN, 1'b0, 16'd1, 16'd0);
    send_request(16'd1, 1'b1);
    setup(ALG_CSCAN, 1'b1, 16'hFFFF, 16'hFFFF);
    send_request(16'd5, 1'b1);
    // Head clamped to last track.
    setup(ALG_LOOK, 1'b0, 16'd300, 16'hFFFF);
    send_request(16'd10, 1'b1);
  endtask

  // Store overflow: more than MaxRequests requests in one batch.
  task automatic test_overflow();
    setup(ALG_SCAN, 1'b0, 16'hFFFF, 16'h8000);
    random_batch(MaxRequests + 3);
  endtask

  // Random settings and batches.
  task automatic test_random();
    int sent;
    logic [15:0] lt;
    sent = 0;
    while (sent < 80) begin
      lt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                       : 16'($urandom_range(1, 400));
      if ($urandom_range(0, 9) == 0) lt = 16'hFFFF;
      setup(3'($urandom_range(0, 7)), 1'($urandom), lt,
            16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, lt)));
      for (int b = 0; b < 3; b++) begin
        automatic int n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18)
                                                      : $urandom_range(1, 8);
        random_batch(n);
        sent += n;
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering words.
  task automatic test_backpressure();
    setup(ALG_SSTF, 1'b0, 16'd500, 16'd250);
    hold_cycles = 600;
    hold_out = 1;
    random_batch(6);
    random_batch(6);
    random_batch(4);
    drain();
  endtask

  // Receiver with random stalls.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_out = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    visit_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (visits_due.size() == 0) begin
        $error("unexpected result word: track %0d", out_tdata[15:0]);
        errors++;
      end else begin
        e = visits_due.pop_front();
        if (out_tdata[15:0] !== e.track) begin
          $error("served_track expected %0d got %0d", e.track, out_tdata[15:0]);
          errors++;
        end
        if (out_tuser !== e.boundary) begin
          $error("is_boundary expected %0d got %0d", e.boundary, out_tuser);
          errors++;
        end
        if (out_tdata[36:16] !== e.travel) begin
          $error("total_movement expected %0d got %0d", e.travel, out_tdata[36:16]);
          errors++;
        end
        if (out_tlast !== e.run_end) begin
          $error("end_of_run expected %0d got %0d", e.run_end, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    batches = 0;
    results_seen = 0;
    idle_on = 1;
    hold_out = 0;
    sched_alg = ALG_FCFS;
    sched_down = 1'b0;
    sched_last = 16'd199;
    sched_start = 16'd0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    idle_on = 0;
    test_overflow();
    drain();
    $display("Covered %0d batches and %0d result words over all algorithms,", batches,
             results_seen);
    $display("both sweep directions, clamping, store overflow and output stalls.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: disk_request_scheduler_top.f
src/drs_pkg.sv
src/drs_cell.sv
src/drs_seek.sv
src/disk_request_scheduler_top.sv
verif/testbench.sv
